@@ src/spfra_pkg.sv @@
// Shared types and constants of the slot pool free ring allocator.
package spfra_pkg;

  // Fixed field widths of the request and result channels.
  localparam int CMD_W  = 2;
  localparam int IDX_W  = 4;
  localparam int DATA_W = 32;
  localparam int ST_W   = 2;
  localparam int OCC_W  = 5;

  // Request commands.
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;  // write one entry of the clearing pass
    logic accept;  // capture the incoming request
    logic rd_en;   // read the ring and the slot store
    logic exec;    // update state and load the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;  // the clearing pass is at its last entry
    logic out_busy;  // the result register holds a result that is not taken
  } ctrl_sts_t;

endpackage

@@ src/spfra_ctrl.sv @@
// Controller state machine of the slot pool free ring allocator.
module spfra_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  spfra_pkg::ctrl_sts_t  sts,
  output spfra_pkg::ctrl_cmd_t  cmd
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_EXEC  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        // Hold here until the result register can take the new result.
        if (!sts.out_busy) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

@@ src/spfra_dp.sv @@
// Datapath of the slot pool free ring allocator: ring, slot store, pointers and result register.
module spfra_dp #(
  parameter int SLOTS      = 16,
  parameter int SLOT_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  spfra_pkg::ctrl_cmd_t            cmd,
  output spfra_pkg::ctrl_sts_t            sts,
  input  logic [spfra_pkg::CMD_W-1:0]     in_command,
  input  logic [spfra_pkg::IDX_W-1:0]     in_slot_index,
  input  logic [spfra_pkg::DATA_W-1:0]    in_write_data,
  input  logic                            in_has_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [spfra_pkg::IDX_W-1:0]     out_given_index,
  output logic [spfra_pkg::DATA_W-1:0]    out_read_data,
  output logic [spfra_pkg::ST_W-1:0]      out_status,
  output logic [spfra_pkg::OCC_W-1:0]     out_occupied_count
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  // Width that holds both a request index and the slot count.
  localparam int RW = (IW + 1 > spfra_pkg::IDX_W) ? IW + 1 : spfra_pkg::IDX_W;

  // Request capture.
  logic [spfra_pkg::CMD_W-1:0]  cmd_q_r;
  logic [spfra_pkg::IDX_W-1:0]  raw_idx_r;
  logic [IW-1:0]                idx_r;
  logic [spfra_pkg::DATA_W-1:0] data_r;
  logic                         has_data_r;
  logic [RW-1:0]                idx_red;

  // Control state.
  logic [IW-1:0] take_ptr_r;
  logic [IW-1:0] take_ptr_nxt;
  logic [IW-1:0] give_ptr_r;
  logic [IW-1:0] give_ptr_nxt;
  logic [CW-1:0] used_r;
  logic [CW-1:0] used_nxt;
  logic [IW-1:0] clr_cnt_r;
  logic          out_valid_r;

  // Memories and their ports.
  logic [IW-1:0]         ring_mem_r [SLOTS];
  logic [SLOT_WIDTH-1:0] store_mem_r [SLOTS];
  logic [IW-1:0]         ring_rd_r;
  logic [SLOT_WIDTH-1:0] store_rd_r;
  logic                  ring_we;
  logic [IW-1:0]         ring_wa;
  logic [IW-1:0]         ring_wd;
  logic                  store_we;
  logic [IW-1:0]         store_wa;
  logic [SLOT_WIDTH-1:0] store_wd;

  // Result register.
  logic [spfra_pkg::IDX_W-1:0]  given_r;
  logic [spfra_pkg::IDX_W-1:0]  given_nxt;
  logic [spfra_pkg::DATA_W-1:0] rdata_r;
  logic [spfra_pkg::DATA_W-1:0] rdata_nxt;
  logic [spfra_pkg::ST_W-1:0]   status_r;
  logic [spfra_pkg::ST_W-1:0]   status_nxt;
  logic [spfra_pkg::OCC_W-1:0]  occ_r;

  logic alloc_ok;
  logic free_ok;
  logic is_full;
  logic is_empty;

  // Indices beyond the pool wrap around; a 4-bit index needs at most eight subtractions.
  always_comb begin
    idx_red = RW'(in_slot_index);
    for (int k = 0; k < 8; k++) begin
      if (idx_red >= RW'(SLOTS)) begin
        idx_red = idx_red - RW'(SLOTS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_q_r    <= in_command;
      raw_idx_r  <= in_slot_index;
      idx_r      <= idx_red[IW-1:0];
      data_r     <= in_write_data;
      has_data_r <= in_has_data;
    end
  end

  assign is_full  = (used_r == CW'(SLOTS));
  assign is_empty = (used_r == '0);
  assign alloc_ok = (cmd_q_r == spfra_pkg::CMD_ALLOC) && !is_full;
  assign free_ok  = (cmd_q_r == spfra_pkg::CMD_FREE) && !is_empty;

  always_comb begin
    take_ptr_nxt = take_ptr_r;
    give_ptr_nxt = give_ptr_r;
    used_nxt     = used_r;
    if (cmd.exec && alloc_ok) begin
      take_ptr_nxt = (take_ptr_r == IW'(SLOTS - 1)) ? '0 : take_ptr_r + 1'b1;
      used_nxt     = used_r + 1'b1;
    end
    if (cmd.exec && free_ok) begin
      give_ptr_nxt = (give_ptr_r == IW'(SLOTS - 1)) ? '0 : give_ptr_r + 1'b1;
      used_nxt     = used_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      take_ptr_r <= '0;
      give_ptr_r <= '0;
      used_r     <= '0;
      clr_cnt_r  <= '0;
    end else begin
      take_ptr_r <= take_ptr_nxt;
      give_ptr_r <= give_ptr_nxt;
      used_r     <= used_nxt;
      if (cmd.clr_wr) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  // Write port selection: the clearing pass first, then allocate or free.
  always_comb begin
    ring_we  = 1'b0;
    ring_wa  = clr_cnt_r;
    ring_wd  = clr_cnt_r;
    store_we = 1'b0;
    store_wa = clr_cnt_r;
    store_wd = '0;
    if (cmd.clr_wr) begin
      ring_we  = 1'b1;
      store_we = 1'b1;
    end else if (cmd.exec && alloc_ok) begin
      store_we = 1'b1;
      store_wa = ring_rd_r;
      store_wd = has_data_r ? SLOT_WIDTH'(data_r) : '0;
    end else if (cmd.exec && free_ok) begin
      ring_we  = 1'b1;
      ring_wa  = give_ptr_r;
      ring_wd  = idx_r;
      store_we = 1'b1;
      store_wa = idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem_r[ring_wa] <= ring_wd;
    end
    if (cmd.rd_en) begin
      ring_rd_r <= ring_mem_r[take_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem_r[store_wa] <= store_wd;
    end
    if (cmd.rd_en) begin
      store_rd_r <= store_mem_r[idx_r];
    end
  end

  always_comb begin
    given_nxt  = raw_idx_r;
    rdata_nxt  = '0;
    status_nxt = spfra_pkg::ST_OK;
    case (cmd_q_r)
      spfra_pkg::CMD_ALLOC: begin
        if (is_full) begin
          status_nxt = spfra_pkg::ST_FULL;
          given_nxt  = '0;
        end else begin
          given_nxt = spfra_pkg::IDX_W'(ring_rd_r);
        end
      end
      spfra_pkg::CMD_FREE: begin
        if (is_empty) begin
          status_nxt = spfra_pkg::ST_EMPTY;
        end
      end
      spfra_pkg::CMD_READ: begin
        rdata_nxt = spfra_pkg::DATA_W'(store_rd_r);
      end
      default: begin
        status_nxt = spfra_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      given_r  <= given_nxt;
      rdata_r  <= rdata_nxt;
      status_r <= status_nxt;
      occ_r    <= spfra_pkg::OCC_W'(used_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.clr_last = (clr_cnt_r == IW'(SLOTS - 1));
  assign sts.out_busy = out_valid_r && out_stall;

  assign out_valid          = out_valid_r;
  assign out_given_index    = given_r;
  assign out_read_data      = rdata_r;
  assign out_status         = status_r;
  assign out_occupied_count = occ_r;

endmodule

@@ src/slot_pool_free_ring_allocator_unit.sv @@
// Top level of the slot pool free ring allocator.
// A pool of SLOTS words, each SLOT_WIDTH bits, handed out through a ring of free
// slot indices: allocate takes the index at the take pointer and stores the request's
// word (or zero), free puts an index back at the give pointer and clears the slot, and
// read returns a slot's word; every result carries the occupied count. After reset the
// block runs a clearing pass that loads the ring with every index in order and
// zeroes the slot store, and it stalls its input until that is done. Each request
// then goes through three steps: accepting it, the registered reads of the ring and
// the slot store, and updating the memories and loading the result register. The
// next request is accepted while a result waits at the output; it stays in its final
// step for as long as the earlier result is not taken.
module slot_pool_free_ring_allocator_unit #(
  parameter int SLOTS      = 16,
  parameter int SLOT_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [spfra_pkg::CMD_W-1:0]     in_command,
  input  logic [spfra_pkg::IDX_W-1:0]     in_slot_index,
  input  logic [spfra_pkg::DATA_W-1:0]    in_write_data,
  input  logic                            in_has_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [spfra_pkg::IDX_W-1:0]     out_given_index,
  output logic [spfra_pkg::DATA_W-1:0]    out_read_data,
  output logic [spfra_pkg::ST_W-1:0]      out_status,
  output logic [spfra_pkg::OCC_W-1:0]     out_occupied_count
);

  spfra_pkg::ctrl_cmd_t cmd;
  spfra_pkg::ctrl_sts_t sts;

  spfra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  spfra_dp #(
    .SLOTS      (SLOTS),
    .SLOT_WIDTH (SLOT_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_command         (in_command),
    .in_slot_index      (in_slot_index),
    .in_write_data      (in_write_data),
    .in_has_data        (in_has_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_given_index    (out_given_index),
    .out_read_data      (out_read_data),
    .out_status         (out_status),
    .out_occupied_count (out_occupied_count)
  );

  // A full pool reports index zero and a count equal to the pool size.
  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == spfra_pkg::ST_FULL) |->
      (out_given_index == '0) && (out_occupied_count == spfra_pkg::OCC_W'(SLOTS)))
    else $error("full status with wrong index or count");

  // A rejected free only happens with nothing in use.
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == spfra_pkg::ST_EMPTY) |-> (out_occupied_count == '0))
    else $error("empty status with nonzero count");

  // Only a read returns slot data, so nonzero data comes only with an OK status.
  a_read_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_read_data != '0) |->
      (out_status == spfra_pkg::ST_OK))
    else $error("slot data returned with an error status");

  // One request at a time: after an accept the input stalls.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while another is in work");

endmodule

@@ dv/slot_pool_tb_pkg.sv @@
`timescale 1ns / 1ps
// Request and result types and the expected-result checker for the slot pool testbench.
package slot_pool_tb_pkg;
  import spfra_pkg::*;

  localparam int POOL_SLOTS = 16;

  // The fourth command code does nothing but still returns a result.
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [IDX_W-1:0]  slot_index;
    logic [DATA_W-1:0] write_data;
    logic              has_data;
  } slot_request_t;

  typedef struct packed {
    logic [IDX_W-1:0]  given_index;
    logic [DATA_W-1:0] read_data;
    logic [ST_W-1:0]   status;
    logic [OCC_W-1:0]  occupied;
  } slot_result_t;

  class slot_pool_checker;
    logic [IDX_W-1:0]  free_ring [POOL_SLOTS];
    logic [DATA_W-1:0] slot_word [POOL_SLOTS];
    logic [IDX_W-1:0]  take_ptr;
    logic [IDX_W-1:0]  give_ptr;
    logic [OCC_W-1:0]  used;
    bit                held [POOL_SLOTS];
    slot_result_t      owed_results [$];
    int unsigned       failures;

    function new();
      for (int i = 0; i < POOL_SLOTS; i++) begin
        free_ring[i] = IDX_W'(i);
        slot_word[i] = '0;
        held[i] = 1'b0;
      end
      take_ptr = '0;
      give_ptr = '0;
      used = '0;
      failures = 0;
    endfunction

    // Applies one request to the pool state and returns the result it produces.
    function slot_result_t next_pool_result(slot_request_t rq);
      slot_result_t r;
      logic [IDX_W-1:0] slot;
      r.given_index = rq.slot_index;
      r.read_data = '0;
      r.status = ST_OK;
      case (rq.command)
        CMD_ALLOC: begin
          if (used == POOL_SLOTS) begin
            r.status = ST_FULL;
            r.given_index = '0;
          end else begin
            slot = free_ring[take_ptr];
            slot_word[slot] = rq.has_data ? rq.write_data : '0;
            held[slot] = 1'b1;
            take_ptr = take_ptr + 1'b1;
            used = used + 1'b1;
            r.given_index = slot;
          end
        end
        CMD_FREE: begin
          if (used == 0) begin
            r.status = ST_EMPTY;
          end else begin
            // A slot that is already free goes back into the ring all the same.
            free_ring[give_ptr] = rq.slot_index;
            give_ptr = give_ptr + 1'b1;
            used = used - 1'b1;
            slot_word[rq.slot_index] = '0;
            held[rq.slot_index] = 1'b0;
          end
        end
        CMD_READ: r.read_data = slot_word[rq.slot_index];
        default: ;
      endcase
      r.occupied = used;
      return r;
    endfunction

    function void note_request(slot_request_t rq);
      owed_results.push_back(next_pool_result(rq));
    endfunction

    function void check_result(slot_result_t got);
      slot_result_t want;
      if (owed_results.size() == 0) begin
        $error("result with no request outstanding, given_index %0d", got.given_index);
        failures++;
        return;
      end
      want = owed_results.pop_front();
      if (got.given_index !== want.given_index) begin
        $error("given_index: expected %0d, actual %0d", want.given_index, got.given_index);
        failures++;
      end
      if (got.read_data !== want.read_data) begin
        $error("read_data: expected %h, actual %h", want.read_data, got.read_data);
        failures++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        failures++;
      end
      if (got.occupied !== want.occupied) begin
        $error("occupied_count: expected %0d, actual %0d", want.occupied, got.occupied);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return owed_results.size();
    endfunction

    // Picks a slot that is currently handed out, or any slot when none is.
    function logic [IDX_W-1:0] pick_held_slot();
      int live [$];
      for (int i = 0; i < POOL_SLOTS; i++) begin
        if (held[i]) live.push_back(i);
      end
      if (live.size() == 0) return IDX_W'($urandom_range(0, POOL_SLOTS - 1));
      return IDX_W'(live[$urandom_range(0, live.size() - 1)]);
    endfunction
  endclass

endpackage

@@ dv/tb_slot_pool_free_ring_allocator_unit.sv @@
`timescale 1ns / 1ps
// Testbench top for the slot pool free ring allocator: directed and random requests.
module tb_slot_pool_free_ring_allocator_unit;
  import spfra_pkg::*;
  import slot_pool_tb_pkg::*;

  localparam int RANDOM_ITEMS = 1850;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic [CMD_W-1:0]  in_command = CMD_ALLOC;
  logic [IDX_W-1:0]  in_slot_index = '0;
  logic [DATA_W-1:0] in_write_data = '0;
  logic              in_has_data = 1'b0;
  logic              out_stall = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic [IDX_W-1:0]  out_given_index;
  logic [DATA_W-1:0] out_read_data;
  logic [ST_W-1:0]   out_status;
  logic [OCC_W-1:0]  out_occupied_count;

  slot_pool_checker pool;
  int unsigned feed_idle_pct = 0;
  int unsigned drain_stall_pct = 0;
  int unsigned alloc_pct = 40;
  int unsigned free_pct = 30;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;
  bit          quiet_tail = 1'b0;

  slot_pool_free_ring_allocator_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_slot_index      (in_slot_index),
    .in_write_data      (in_write_data),
    .in_has_data        (in_has_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_given_index    (out_given_index),
    .out_read_data      (out_read_data),
    .out_status         (out_status),
    .out_occupied_count (out_occupied_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("slot_pool_free_ring_allocator_unit test failed");
      $finish;
    end
  end

  // Result side back-pressure comes in bursts of random length.
  always @(posedge clk) begin
    if (!rst_n || quiet_tail) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < drain_stall_pct) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      pool.check_result(slot_result_t'{out_given_index, out_read_data, out_status,
                                       out_occupied_count});
  end

  task automatic send_request(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                              logic [DATA_W-1:0] data, logic hd);
    slot_request_t rq;
    rq = slot_request_t'{cmd, idx, data, hd};
    in_valid <= 1'b1;
    in_command <= cmd;
    in_slot_index <= idx;
    in_write_data <= data;
    in_has_data <= hd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pool.note_request(rq);
  endtask

  // Sender gap; the payload wanders while valid is low.
  task automatic hold_off(int unsigned cycles);
    in_valid <= 1'b0;
    in_command <= CMD_W'($urandom());
    in_slot_index <= IDX_W'($urandom());
    in_write_data <= $urandom();
    in_has_data <= 1'($urandom());
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pool.pending() != 0) @(posedge clk);
  endtask

  task automatic random_request();
    int unsigned roll;
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] data;
    roll = $urandom_range(0, 99);
    if (roll < alloc_pct) cmd = CMD_ALLOC;
    else if (roll < alloc_pct + free_pct) cmd = CMD_FREE;
    else if (roll < 95) cmd = CMD_READ;
    else cmd = CMD_NOP;
    // Frees and reads mostly target live slots; the rest use a random index, which can hit free ones and double free.
    if (cmd != CMD_ALLOC && cmd != CMD_NOP && $urandom_range(0, 99) < 80)
      idx = pool.pick_held_slot();
    else
      idx = IDX_W'($urandom());
    case ($urandom_range(0, 9))
      0: data = '0;
      1: data = '1;
      default: data = $urandom();
    endcase
    if (!quiet_tail && $urandom_range(0, 99) < feed_idle_pct)
      hold_off($urandom_range(1, 7));
    send_request(cmd, idx, data, $urandom_range(0, 3) != 0);
  endtask

  initial begin
    pool = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_request(CMD_FREE, 4'd5, 32'h0, 1'b0);
    send_request(CMD_NOP, 4'd15, 32'hFFFF_FFFF, 1'b1);
    send_request(CMD_READ, 4'd0, 32'h0, 1'b0);
    for (int i = 0; i < POOL_SLOTS; i++) begin
      case (i % 4)
        0: send_request(CMD_ALLOC, 4'd15, 32'hFFFF_FFFF, 1'b1);
        1: send_request(CMD_ALLOC, 4'd0, 32'hFFFF_FFFF, 1'b0);
        2: send_request(CMD_ALLOC, IDX_W'(i), 32'h0, 1'b1);
        default: send_request(CMD_ALLOC, IDX_W'(i), $urandom(), 1'b1);
      endcase
    end
    send_request(CMD_ALLOC, 4'd7, 32'hFFFF_FFFF, 1'b1);
    send_request(CMD_READ, 4'd0, 32'h0, 1'b0);
    send_request(CMD_READ, 4'd15, 32'h0, 1'b0);
    send_request(CMD_FREE, 4'd3, 32'h0, 1'b0);
    send_request(CMD_FREE, 4'd3, 32'h0, 1'b0);
    send_request(CMD_READ, 4'd3, 32'h0, 1'b0);
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        feed_idle_pct = 20 * $urandom_range(0, 3);
        drain_stall_pct = 20 * $urandom_range(0, 3);
        // Pick a filling, draining or balanced mix at random so both ends of the pool are reached.
        case ($urandom_range(0, 2))
          0: begin alloc_pct = 60; free_pct = 20; end
          1: begin alloc_pct = 20; free_pct = 60; end
          default: begin alloc_pct = 40; free_pct = 35; end
        endcase
      end
      if (n == RANDOM_ITEMS / 2) wait_drained();
      if (n == RANDOM_ITEMS - 250) quiet_tail = 1'b1;
      random_request();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pool.failures == 0 && pool.pending() == 0)
      $display("slot_pool_free_ring_allocator_unit test passed");
    else
      $display("slot_pool_free_ring_allocator_unit test failed");
    $finish;
  end

endmodule
